>>> rtl/deq_pkg.sv
package deq_pkg;

   localparam int unsigned DEF_DEPTH       = 16;
   localparam int unsigned DEF_VALUE_WIDTH = 32;

   localparam int unsigned REQ_TYPE_W = 3;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 9;

   localparam int unsigned REQ_DATA_W = 40;   // value, position
   localparam int unsigned RSP_DATA_W = 48;   // removed_value, count, is_empty, pad

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_INSERT     = 3'd4,
      REQ_CLEAR      = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // what one cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LOAD  = 2'd1,
      CELL_LEFT  = 2'd2,   // take the neighbor toward the front
      CELL_RIGHT = 2'd3    // take the neighbor toward the back
   } cell_op_type;

endpackage

>>> rtl/deq_cell.sv
module deq_cell #(
   parameter int unsigned WIDTH = deq_pkg::DEF_VALUE_WIDTH
) (
   input  logic                  clock,
   input  deq_pkg::cell_op_type  op,
   input  logic [WIDTH-1:0]      load_data,
   input  logic [WIDTH-1:0]      left_data,
   input  logic [WIDTH-1:0]      right_data,
   output logic [WIDTH-1:0]      data
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      unique case (op)
         deq_pkg::CELL_LOAD:  data_in = load_data;
         deq_pkg::CELL_LEFT:  data_in = left_data;
         deq_pkg::CELL_RIGHT: data_in = right_data;
         default:             data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/deque_with_indexed_insert.sv
// Deque with indexed insert, built as a row of entry cells.
// The response word is registered and shows in the cycle after its request word is accepted.
// Throughput: one request word per cycle while no response word is stalled; every operation,
// insert included, moves all the cells it affects in parallel.
// Reset (synchronous, active high) empties the store and drops any pending
// response; cell contents are left as they are and never read until written.
module deque_with_indexed_insert #(
   parameter int unsigned DEPTH       = deq_pkg::DEF_DEPTH,
   parameter int unsigned VALUE_WIDTH = deq_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]   req_tdata,  // [31:0] value, [39:32] position
   input  logic [deq_pkg::REQ_TYPE_W-1:0]   req_tuser,  // [2:0] req_type
   // response side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [deq_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [31:0] removed_value,
                                                        // [40:32] count, [41] is_empty,
                                                        // [47:42] zero
   output logic [deq_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);

   // count needs to reach DEPTH itself; cell index only DEPTH-1
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ---------------- request word fields ----------------
   logic [deq_pkg::VALUE_W-1:0]    req_value;
   logic [deq_pkg::POS_W-1:0]      req_position;
   logic [deq_pkg::REQ_TYPE_W-1:0] req_kind;
   logic                           req_fire;

   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[39:32];
   assign req_kind     = req_tuser;

   // ---------------- state ----------------
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         rsp_valid_ff;
   deq_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [deq_pkg::VALUE_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]             rsp_count_ff;

   // response register frees up when empty or being taken this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- decode ----------------
   logic                    is_full, is_none;
   logic                    do_insert, do_pop_front, do_pop_back, do_clear;
   logic [CNT_W-1:0]        ins_pos;
   logic [VALUE_WIDTH-1:0]  load_value;
   logic [VALUE_WIDTH-1:0]  cell_data [DEPTH];
   logic [IDX_W-1:0]        back_idx;
   logic [CNT_W-1:0]        count_dec;

   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_none    = (count_ff == '0);
   assign load_value = VALUE_WIDTH'(req_value);
   assign count_dec  = count_ff - CNT_W'(1);
   assign back_idx   = count_dec[IDX_W-1:0];

   always_comb begin
      rsp_status_in  = deq_pkg::ST_DONE;
      rsp_removed_in = '0;
      count_in       = count_ff;
      do_insert      = 1'b0;
      do_pop_front   = 1'b0;
      do_pop_back    = 1'b0;
      do_clear       = 1'b0;
      ins_pos        = count_ff;
      unique case (req_kind)
         deq_pkg::REQ_PUSH_BACK,
         deq_pkg::REQ_PUSH_FRONT: begin
            ins_pos = (req_kind == deq_pkg::REQ_PUSH_BACK) ? count_ff : '0;
            if (is_full) begin
               rsp_status_in = deq_pkg::ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         deq_pkg::REQ_INSERT: begin
            ins_pos = CNT_W'(req_position);
            // range check wins over the full check
            if ({1'b0, req_position} > deq_pkg::COUNT_W'(count_ff)) begin
               rsp_status_in = deq_pkg::ST_RANGE;
            end else if (is_full) begin
               rsp_status_in = deq_pkg::ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         deq_pkg::REQ_POP_BACK,
         deq_pkg::REQ_POP_FRONT: begin
            if (is_none) begin
               rsp_status_in = deq_pkg::ST_EMPTY;
            end else if (req_kind == deq_pkg::REQ_POP_BACK) begin
               do_pop_back    = 1'b1;
               rsp_removed_in = deq_pkg::VALUE_W'(cell_data[back_idx]);
            end else begin
               do_pop_front   = 1'b1;
               rsp_removed_in = deq_pkg::VALUE_W'(cell_data[0]);
            end
         end
         deq_pkg::REQ_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            // unused codes leave the store alone and report done
         end
      endcase

      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop_front || do_pop_back) begin
         count_in = count_dec;
      end else if (do_clear) begin
         count_in = '0;
      end
   end

   // ---------------- cell row ----------------
   // Insert: the cell at ins_pos loads, cells behind it up to count shift back.
   // Pop front: every cell takes its back neighbor; the tail cell keeps its own.
   // Pop back and clear only move the count.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      deq_pkg::cell_op_type  op;
      logic [VALUE_WIDTH-1:0] left_data;
      logic [VALUE_WIDTH-1:0] right_data;

      always_comb begin
         op = deq_pkg::CELL_HOLD;
         if (req_fire) begin
            priority if (do_insert && (CNT_W'(i) == ins_pos)) begin
               op = deq_pkg::CELL_LOAD;
            end else if (do_insert && (CNT_W'(i) > ins_pos) && (CNT_W'(i) <= count_ff)) begin
               op = deq_pkg::CELL_LEFT;
            end else if (do_pop_front) begin
               op = deq_pkg::CELL_RIGHT;
            end else begin
               op = deq_pkg::CELL_HOLD;
            end
         end
      end

      if (i == 0) begin : g_front
         assign left_data = load_value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      deq_cell #(
         .WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .load_data  (load_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with the word that produced it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_count_ff   <= count_in;
      end
   end

   // ---------------- response word ----------------
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tuser        = rsp_status_ff;
   assign rsp_tdata[31:0]  = rsp_removed_ff;
   assign rsp_tdata[40:32] = deq_pkg::COUNT_W'(rsp_count_ff);
   assign rsp_tdata[41]    = (rsp_count_ff == '0);
   assign rsp_tdata[47:42] = '0;

endmodule

>>> rtl/deq_checker.sv
module deq_checker #(
   parameter int unsigned DEPTH = deq_pkg::DEF_DEPTH
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [deq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [deq_pkg::STATUS_W-1:0]   rsp_tuser
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // every accepted request shows a response next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response one cycle after request");

   // empty flag tracks the count, count never above depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[41] == (rsp_tdata[40:32] == 9'd0))
                     && (rsp_tdata[40:32] <= deq_pkg::COUNT_W'(DEPTH)))
      else $error("count or empty flag inconsistent");

   // a failed pop reports an empty store and no value
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == deq_pkg::ST_EMPTY)
      |-> (rsp_tdata[40:32] == 9'd0) && (rsp_tdata[31:0] == 32'd0))
      else $error("empty status with nonzero count or value");

   // a dropped push or insert means the store is at depth
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == deq_pkg::ST_FULL)
      |-> (rsp_tdata[40:32] == deq_pkg::COUNT_W'(DEPTH)))
      else $error("full status below depth");

endmodule

bind deque_with_indexed_insert deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
